@@ design/fsts_pkg.sv @@
// Shared types and constants of the fixed-step tick scheduler.
package fsts_pkg;

  localparam int unsigned MAX_TICKS = 16;
  localparam int unsigned TICK_W    = 7;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned PERIOD_W  = 30;
  localparam int unsigned THRESH_W  = 32;
  localparam int unsigned GAP_W     = 32;
  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(33333333);
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(250000000);

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_BEGIN   = 2'd1,
    MODE_COMMIT  = 2'd2,
    MODE_RESET   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIM_PERIOD    = 2'd0,
    CFG_GAP_THRESHOLD = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] raw_now;
    logic [TIME_W-1:0] scaled_now;
    logic              interpolate;
    logic              scale_is_unity;
    logic              scale_is_zero;
  } in_req_t;

  typedef struct packed {
    logic [GAP_W-1:0]   frame_gap_ns;
    logic [EPOCH_W-1:0] epoch;
    logic               interpolating;
    logic               separate_presentation;
    logic [TICK_W-1:0]  tick_count;
    logic               sim_frame;
  } out_res_t;

endpackage

@@ design/fsts_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface fsts_in_if;
  logic              valid;
  logic              ready;
  fsts_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsts_out_if;
  logic               valid;
  logic               ready;
  fsts_pkg::out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/fixed_step_tick_scheduler.sv @@
// Top level of the fixed-step tick scheduler: sequencer around one shared 64-bit adder.
//
// Usage: each request on in_req carries a mode (frame advance, tick begin,
// tick commit, timer reset) and raw/scaled nanosecond timestamps. Exactly one
// result leaves on out_res per request, in order. Config writes (cfg_we,
// cfg_index, cfg_wdata) set the tick period and the raw gap threshold; issue
// them only while the block is idle. Unknown indexes are ignored.
// Sequence: begin, commit and reset requests take one step, then the done step.
// An advance takes the raw and scaled gap steps; with separate presentation the
// target step; if time also runs and the raw gap is normal, the difference step
// and the tick loop, one adder pass per due tick plus one closing compare.
// in_req.ready is high only while idle, so one request is in flight at a time.
// Output: results sit in an output register; a new request is accepted while
// a finished result still waits. If the receiver stalls with a result held,
// the next finished result waits in the done step until the register frees.
// Reset: rst_n is synchronous, active low; it restores the register defaults,
// the epoch counter to one and clears the timing state kept between requests.
module fixed_step_tick_scheduler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fsts_in_if.sink                              in_req,
  fsts_out_if.source                           out_res,
  input  logic                                 cfg_we,
  input  logic [fsts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsts_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_RGAP, S_SGAP, S_TARGET, S_DIFF, S_LOOP,
    S_BEGIN, S_COMMIT, S_RESET, S_DONE
  } state_t;

  localparam int unsigned TW = fsts_pkg::TIME_W;

  state_t                            state_r, state_nxt;
  fsts_pkg::in_req_t                 item_r, item_nxt;
  logic [fsts_pkg::PERIOD_W-1:0]     period_r, period_nxt;
  logic [fsts_pkg::THRESH_W-1:0]     thresh_r, thresh_nxt;
  logic                              started_r, started_nxt;
  logic [TW-1:0]                     last_raw_r, last_raw_nxt;
  logic [TW-1:0]                     last_scaled_r, last_scaled_nxt;
  logic [TW-1:0]                     snapshot_r, snapshot_nxt;
  logic [TW-1:0]                     pending_r, pending_nxt;
  logic                              tick_active_r, tick_active_nxt;
  logic [fsts_pkg::EPOCH_W-1:0]      epoch_r, epoch_nxt;
  logic                              mode_seen_r, mode_seen_nxt;
  logic                              sep_r, sep_nxt;
  logic                              interp_r, interp_nxt;
  logic                              stop_r, stop_nxt;
  logic [TW-1:0]                     raw_gap_r, raw_gap_nxt;
  logic [fsts_pkg::GAP_W-1:0]        gap_r, gap_nxt;
  logic                              abnormal_r, abnormal_nxt;
  logic [TW-1:0]                     target_r, target_nxt;
  logic [TW-1:0]                     diff_r, diff_nxt;
  logic [fsts_pkg::TICK_W-1:0]       ticks_r, ticks_nxt;
  logic                              out_valid_r, out_valid_nxt;
  fsts_pkg::out_res_t                out_data_r, out_data_nxt;

  // Shared adder/subtractor
  logic [TW-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub;

  logic [TW-1:0] period_ext;
  logic          accept;
  logic          abnormal_now;
  logic          sep_now, changed_now;
  logic          due;

  assign period_ext = TW'(period_r);
  assign accept     = in_req.valid && in_req.ready;

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_RGAP: begin
        alu_a = item_r.raw_now; alu_b = last_raw_r; alu_sub = 1'b1;
      end
      S_SGAP: begin
        alu_a = item_r.scaled_now; alu_b = last_scaled_r; alu_sub = 1'b1;
      end
      S_TARGET, S_RESET: begin
        alu_a = item_r.scaled_now; alu_b = period_ext; alu_sub = 1'b1;
      end
      S_DIFF: begin
        alu_a = snapshot_r; alu_b = target_r; alu_sub = 1'b1;
      end
      S_LOOP: begin
        alu_a = diff_r; alu_b = period_ext;
      end
      S_BEGIN, S_COMMIT: begin
        alu_a = snapshot_r; alu_b = period_ext;
      end
      S_IDLE, S_DONE: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + TW'(alu_sub);
  end

  // Raw gap is abnormal only when non-negative and above the threshold
  assign abnormal_now = !raw_gap_r[TW-1] &&
                        ((raw_gap_r[TW-1:32] != '0) || (raw_gap_r[31:0] > thresh_r));
  assign sep_now      = item_r.interpolate || !item_r.scale_is_unity;
  assign changed_now  = mode_seen_r &&
                        ({sep_now, item_r.interpolate, item_r.scale_is_zero} !=
                         {sep_r, interp_r, stop_r});
  // diff_r holds proj - target; alu_y is the same after one more period
  assign due = item_r.interpolate ? diff_r[TW-1] : ((alu_y == '0) || alu_y[TW-1]);

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    period_nxt      = period_r;
    thresh_nxt      = thresh_r;
    started_nxt     = started_r;
    last_raw_nxt    = last_raw_r;
    last_scaled_nxt = last_scaled_r;
    snapshot_nxt    = snapshot_r;
    pending_nxt     = pending_r;
    tick_active_nxt = tick_active_r;
    epoch_nxt       = epoch_r;
    mode_seen_nxt   = mode_seen_r;
    sep_nxt         = sep_r;
    interp_nxt      = interp_r;
    stop_nxt        = stop_r;
    raw_gap_nxt     = raw_gap_r;
    gap_nxt         = gap_r;
    abnormal_nxt    = abnormal_r;
    target_nxt      = target_r;
    diff_nxt        = diff_r;
    ticks_nxt       = ticks_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    // Drop the held result once taken
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        fsts_pkg::CFG_SIM_PERIOD:    period_nxt = cfg_wdata[fsts_pkg::PERIOD_W-1:0];
        fsts_pkg::CFG_GAP_THRESHOLD: thresh_nxt = cfg_wdata[fsts_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_req.data;
          gap_nxt   = '0;
          ticks_nxt = '0;
          // First advance or reset seeds the samples
          if (!started_r && (in_req.data.mode == fsts_pkg::MODE_ADVANCE ||
                             in_req.data.mode == fsts_pkg::MODE_RESET)) begin
            last_raw_nxt    = in_req.data.raw_now;
            last_scaled_nxt = in_req.data.scaled_now;
            snapshot_nxt    = in_req.data.scaled_now;
            pending_nxt     = in_req.data.scaled_now;
            started_nxt     = 1'b1;
          end
          unique case (fsts_pkg::mode_t'(in_req.data.mode))
            fsts_pkg::MODE_ADVANCE: state_nxt = S_RGAP;
            fsts_pkg::MODE_BEGIN:   state_nxt = S_BEGIN;
            fsts_pkg::MODE_COMMIT:  state_nxt = S_COMMIT;
            fsts_pkg::MODE_RESET:   state_nxt = S_RESET;
            default:                state_nxt = S_RESET;
          endcase
        end
      end
      S_RGAP: begin
        raw_gap_nxt = alu_y;
        state_nxt   = S_SGAP;
      end
      S_SGAP: begin
        // Clamp the scaled gap to the unsigned 32-bit range
        if (alu_y[TW-1]) begin
          gap_nxt = '0;
        end else if (alu_y[TW-2:32] != '0) begin
          gap_nxt = '1;
        end else begin
          gap_nxt = alu_y[31:0];
        end
        last_raw_nxt    = item_r.raw_now;
        last_scaled_nxt = item_r.scaled_now;
        abnormal_nxt    = abnormal_now;
        if (changed_now || abnormal_now) begin
          epoch_nxt = epoch_r + 1'b1;
        end
        mode_seen_nxt = 1'b1;
        sep_nxt       = sep_now;
        interp_nxt    = item_r.interpolate;
        stop_nxt      = item_r.scale_is_zero;
        if (!sep_now) begin
          snapshot_nxt = item_r.scaled_now;
          ticks_nxt    = fsts_pkg::TICK_W'(1);
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_TARGET;
        end
      end
      S_TARGET: begin
        target_nxt = item_r.interpolate ? alu_y : item_r.scaled_now;
        if (item_r.scale_is_zero || abnormal_r) begin
          snapshot_nxt = item_r.interpolate ? alu_y : item_r.scaled_now;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_nxt  = alu_y;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (ticks_r == fsts_pkg::TICK_W'(fsts_pkg::MAX_TICKS) || !due) begin
          state_nxt = S_DONE;
        end else begin
          diff_nxt  = alu_y;
          ticks_nxt = ticks_r + 1'b1;
        end
      end
      S_BEGIN: begin
        pending_nxt     = sep_r ? alu_y : last_scaled_r;
        tick_active_nxt = 1'b1;
        state_nxt       = S_DONE;
      end
      S_COMMIT: begin
        if (tick_active_r) begin
          snapshot_nxt    = pending_r;
          tick_active_nxt = 1'b0;
        end else begin
          snapshot_nxt = alu_y;
        end
        state_nxt = S_DONE;
      end
      S_RESET: begin
        last_raw_nxt    = item_r.raw_now;
        last_scaled_nxt = item_r.scaled_now;
        snapshot_nxt    = alu_y;
        pending_nxt     = alu_y;
        tick_active_nxt = 1'b0;
        epoch_nxt       = epoch_r + 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt                       = 1'b1;
          out_data_nxt.frame_gap_ns           = gap_r;
          out_data_nxt.epoch                  = epoch_r;
          out_data_nxt.interpolating          = interp_r;
          out_data_nxt.separate_presentation  = sep_r;
          out_data_nxt.tick_count             = ticks_r;
          out_data_nxt.sim_frame              = !sep_r || tick_active_r;
          state_nxt                           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      period_r      <= fsts_pkg::PERIOD_RST;
      thresh_r      <= fsts_pkg::THRESH_RST;
      started_r     <= 1'b0;
      last_raw_r    <= '0;
      last_scaled_r <= '0;
      snapshot_r    <= '0;
      pending_r     <= '0;
      tick_active_r <= 1'b0;
      epoch_r       <= fsts_pkg::EPOCH_W'(1);
      mode_seen_r   <= 1'b0;
      sep_r         <= 1'b0;
      interp_r      <= 1'b0;
      stop_r        <= 1'b0;
      ticks_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      period_r      <= period_nxt;
      thresh_r      <= thresh_nxt;
      started_r     <= started_nxt;
      last_raw_r    <= last_raw_nxt;
      last_scaled_r <= last_scaled_nxt;
      snapshot_r    <= snapshot_nxt;
      pending_r     <= pending_nxt;
      tick_active_r <= tick_active_nxt;
      epoch_r       <= epoch_nxt;
      mode_seen_r   <= mode_seen_nxt;
      sep_r         <= sep_nxt;
      interp_r      <= interp_nxt;
      stop_r        <= stop_nxt;
      ticks_r       <= ticks_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    raw_gap_r  <= raw_gap_nxt;
    gap_r      <= gap_nxt;
    abnormal_r <= abnormal_nxt;
    target_r   <= target_nxt;
    diff_r     <= diff_nxt;
    out_data_r <= out_data_nxt;
  end

  // The tick loop never runs past its bound
  a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_r <= fsts_pkg::TICK_W'(fsts_pkg::MAX_TICKS))
    else $error("tick counter beyond MAX_TICKS");

  // One request in flight: accepting closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  // The epoch only holds or steps up by one
  a_epoch_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> (epoch_r == $past(epoch_r) ||
                           epoch_r == $past(epoch_r) + 1'b1))
    else $error("epoch jumped");

  // A held result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_res.ready) |=> state_r == S_DONE)
    else $error("result register overwritten while stalled");

endmodule

@@ tb/tb_fixed_step_tick_scheduler.sv @@
// Self-checking testbench for the fixed-step tick scheduler: directed and random requests.
module tb_fixed_step_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import fsts_pkg::*;

  // Register indexes that the block has no register for; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Cycles to let pass after the last result before touching the registers.
  localparam int unsigned SETTLE_CYCLES  = 30;
  // Cycles with no request, result or register write before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Long receiver hold-off, so that the result register and the done step both fill.
  localparam int unsigned HOLD_OFF_CYCLES = 240;

  // Presentation flags recorded at the latest advance.
  typedef struct packed {
    logic stopped;
    logic interp;
    logic sep;
  } pres_flags_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  fsts_in_if  in_ch ();
  fsts_out_if out_ch ();

  fixed_step_tick_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] cfg_period;
  logic [THRESH_W-1:0] cfg_thresh;
  logic                started_q;
  logic [TIME_W-1:0]   last_raw;
  logic [TIME_W-1:0]   last_scaled;
  logic [TIME_W-1:0]   snap_time;
  logic [TIME_W-1:0]   pend_time;
  logic                tick_open;
  logic [EPOCH_W-1:0]  epoch_q;
  logic                flags_valid;
  pres_flags_t         flags_q;

  in_req_t  req_backlog[$];   // requests waiting for the driver
  out_res_t results_due[$];   // results the block owes, oldest first

  int unsigned reqs_queued    = 0;
  int unsigned reqs_accepted  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned capped_frames  = 0;
  int unsigned saturated_gaps = 0;

  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  // Signed comparison of wrapping timestamps: a lies before b.
  function automatic logic ts_before(logic [TIME_W-1:0] a, b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

  // Latch the first timestamps seen; later calls leave the samples alone.
  function automatic void load_first_sample(logic [TIME_W-1:0] raw, scaled);
    if (!started_q) begin
      last_raw    = raw;
      last_scaled = scaled;
      snap_time   = scaled;
      pend_time   = scaled;
      started_q   = 1'b1;
    end
  endfunction

  // Advance the scheduler state by one request and return the result it owes.
  function automatic out_res_t step_scheduler(in_req_t rq);
    out_res_t          res;
    logic [TIME_W-1:0] raw_gap;
    logic [TIME_W-1:0] sc_gap;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] proj;
    logic [TIME_W-1:0] next_t;
    logic [TIME_W-1:0] period64;
    pres_flags_t       flags;
    logic              abnormal;
    logic              due;
    int unsigned       ticks;
    res      = '0;
    ticks    = 0;
    period64 = TIME_W'(cfg_period);
    case (mode_t'(rq.mode))
      MODE_ADVANCE: begin
        load_first_sample(rq.raw_now, rq.scaled_now);
        raw_gap     = rq.raw_now - last_raw;
        sc_gap      = rq.scaled_now - last_scaled;
        last_raw    = rq.raw_now;
        last_scaled = rq.scaled_now;
        // Clamp the scaled gap: negative reads as zero, above 32 bits saturates.
        if (sc_gap[TIME_W-1]) begin
          res.frame_gap_ns = '0;
        end else if (sc_gap[TIME_W-1:GAP_W] != '0) begin
          res.frame_gap_ns = '1;
        end else begin
          res.frame_gap_ns = sc_gap[GAP_W-1:0];
        end
        flags.sep     = rq.interpolate | ~rq.scale_is_unity;
        flags.interp  = rq.interpolate;
        flags.stopped = rq.scale_is_zero;
        abnormal = !raw_gap[TIME_W-1] && (raw_gap > TIME_W'(cfg_thresh));
        if ((flags_valid && flags != flags_q) || abnormal) begin
          epoch_q = epoch_q + 1'b1;
        end
        flags_valid = 1'b1;
        flags_q     = flags;
        if (!flags.sep) begin
          snap_time = rq.scaled_now;
          ticks     = 1;
        end else begin
          target = rq.interpolate ? rq.scaled_now - period64 : rq.scaled_now;
          if (flags.stopped || abnormal) begin
            snap_time = target;
          end else begin
            // Count due periods from the snapshot; the snapshot itself stays put.
            proj = snap_time;
            due  = 1'b1;
            while (due && ticks < MAX_TICKS) begin
              next_t = proj + period64;
              if (rq.interpolate) begin
                due = ts_before(proj, target);
              end else begin
                due = (next_t == target) || ts_before(next_t, target);
              end
              if (due) begin
                proj  = next_t;
                ticks = ticks + 1;
              end
            end
          end
        end
      end
      MODE_BEGIN: begin
        pend_time = flags_q.sep ? snap_time + period64 : last_scaled;
        tick_open = 1'b1;
      end
      MODE_COMMIT: begin
        if (tick_open) begin
          snap_time = pend_time;
          tick_open = 1'b0;
        end else begin
          snap_time = snap_time + period64;
        end
      end
      MODE_RESET: begin
        load_first_sample(rq.raw_now, rq.scaled_now);
        last_raw    = rq.raw_now;
        last_scaled = rq.scaled_now;
        snap_time   = rq.scaled_now - period64;
        pend_time   = snap_time;
        tick_open   = 1'b0;
        epoch_q     = epoch_q + 1'b1;
      end
    endcase
    res.epoch                 = epoch_q;
    res.interpolating         = flags_q.interp;
    res.separate_presentation = flags_q.sep;
    res.tick_count            = TICK_W'(ticks);
    res.sim_frame             = !flags_q.sep || tick_open;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches = mismatches + 1;
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the register port at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_res_t want;
    req_taken = 1'b0;
    res_taken = 1'b0;
    if (!rst_n) begin
      // Mirror the block's reset: default registers, epoch one, no timing state.
      cfg_period  = PERIOD_RST;
      cfg_thresh  = THRESH_RST;
      started_q   = 1'b0;
      last_raw    = '0;
      last_scaled = '0;
      snap_time   = '0;
      pend_time   = '0;
      tick_open   = 1'b0;
      epoch_q     = EPOCH_W'(1);
      flags_valid = 1'b0;
      flags_q     = '0;
    end else begin
      if (cfg_we) begin
        // Keep the low 30 bits of a period write; drop writes to unknown indexes.
        case (cfg_index)
          CFG_SIM_PERIOD:    cfg_period = cfg_wdata[PERIOD_W-1:0];
          CFG_GAP_THRESHOLD: cfg_thresh = cfg_wdata[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        req_taken = 1'b1;
        reqs_accepted = reqs_accepted + 1;
        results_due.push_back(step_scheduler(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        res_taken = 1'b1;
        results_seen = results_seen + 1;
        if (results_due.size() == 0) begin
          mismatches = mismatches + 1;
          $display("[%0t] result 0x%0h arrived with none outstanding", $time, out_ch.data);
        end else begin
          want = results_due.pop_front();
          check_field("frame_gap_ns", want.frame_gap_ns, out_ch.data.frame_gap_ns);
          check_field("epoch", want.epoch, out_ch.data.epoch);
          check_field("interpolating", want.interpolating, out_ch.data.interpolating);
          check_field("separate_presentation", want.separate_presentation,
                      out_ch.data.separate_presentation);
          check_field("tick_count", want.tick_count, out_ch.data.tick_count);
          check_field("sim_frame", want.sim_frame, out_ch.data.sim_frame);
          if (out_ch.data.tick_count == TICK_W'(MAX_TICKS)) begin
            capped_frames = capped_frames + 1;
          end
          if (out_ch.data.frame_gap_ns == '1) begin
            saturated_gaps = saturated_gaps + 1;
          end
        end
      end
    end
  end

  // Wait drawn per request; a calm stretch runs with no gaps at all.
  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer backlog requests at the falling edge, with random gaps
  // ---------------------------------------------------------------------------
  int unsigned tx_wait = 0;
  bit          tx_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (req_taken) begin
        tx_wait = draw_wait(tx_calm);
        if ($urandom_range(0, 63) == 0) begin
          tx_calm = !tx_calm;
        end
      end
      // Hold an offered request until the block takes it.
      if (!in_ch.valid || req_taken) begin
        if (tx_wait > 0) begin
          tx_wait = tx_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_ch.data  <= req_backlog.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall at random; now and then hold off long enough to back up
  // the block while the driver keeps offering
  // ---------------------------------------------------------------------------
  int unsigned rx_wait   = 0;
  int unsigned rx_count  = 0;
  int unsigned hold_left = 0;
  bit          rx_calm   = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        rx_count = rx_count + 1;
        rx_wait  = draw_wait(rx_calm);
        if ($urandom_range(0, 63) == 0) begin
          rx_calm = !rx_calm;
        end
        if (rx_count % 700 == 300) begin
          hold_left = HOLD_OFF_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: abandon the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
    $display("[%0t] watchdog: no progress for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, results_due.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(mode_t m, logic [TIME_W-1:0] raw, scaled,
                                    bit interp, unity, zero);
    in_req_t rq;
    rq.mode           = m;
    rq.raw_now        = raw;
    rq.scaled_now     = scaled;
    rq.interpolate    = interp;
    rq.scale_is_unity = unity;
    rq.scale_is_zero  = zero;
    req_backlog.push_back(rq);
    reqs_queued = reqs_queued + 1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Wait until every request has been taken and every result checked, then
  // let the block drain before the registers are touched.
  task automatic settle();
    while (reqs_accepted != reqs_queued || results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random traffic shaped like a game loop: frames on a running timeline, each
  // followed by a few begin/commit pairs, with scene changes, timer resets,
  // clock hiccups and a share of pure noise. Period and threshold are the
  // register values in force for this stretch.
  task automatic queue_random_traffic(int unsigned n_reqs, logic [TIME_W-1:0] raw_start,
                                      logic [TIME_W-1:0] scaled_start,
                                      int unsigned period, logic [THRESH_W-1:0] thresh);
    logic [TIME_W-1:0] raw_t;
    logic [TIME_W-1:0] scaled_t;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] sc_step;
    int unsigned       stop_at;
    int unsigned       pick;
    int unsigned       span;
    bit                interp;
    bit                unity;
    bit                zero;
    raw_t    = raw_start;
    scaled_t = scaled_start;
    interp   = 1'b0;
    unity    = 1'b1;
    zero     = 1'b0;
    stop_at  = reqs_queued + n_reqs;
    span     = (period == 0) ? 50000000 : 3 * period;
    // Fill away from the falling edge so that the driver sees a whole batch.
    @(posedge clk);
    while (reqs_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        queue_req(mode_t'($urandom_range(0, 3)), rand64(), rand64(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
        raw_t    = raw_t + $urandom_range(0, 1000000);
        scaled_t = scaled_t + $urandom_range(0, 1000000);
        queue_req(MODE_RESET, raw_t, scaled_t, interp, unity, zero);
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          interp = 1'($urandom_range(0, 1));
          unity  = ($urandom_range(0, 9) < 7);
          zero   = ($urandom_range(0, 9) == 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          step = TIME_W'(period) * $urandom_range(0, 4);
        end else if (pick < 70) begin
          step = TIME_W'($urandom_range(0, span));
        end else if (pick < 78) begin
          step = TIME_W'(thresh) + 1 + $urandom_range(0, 1000);
        end else if (pick < 83) begin
          step = TIME_W'(thresh);
        end else if (pick < 90) begin
          step = -TIME_W'($urandom_range(1, 100000000));
        end else if (pick < 94) begin
          step = rand64();
        end else begin
          step = TIME_W'($urandom_range(0, 1000));
        end
        // Scaled clock: frozen, in step with raw, or stretched by a quarter-step factor.
        if (zero) begin
          sc_step = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom_range(0, 1000)) : '0;
        end else if (unity) begin
          sc_step = step;
        end else begin
          sc_step = (step * $urandom_range(0, 8)) >> 2;
        end
        raw_t    = raw_t + step;
        scaled_t = scaled_t + sc_step;
        queue_req(MODE_ADVANCE, raw_t, scaled_t, interp, unity, zero);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 9) != 0) begin
            queue_req(MODE_BEGIN, raw_t, scaled_t, interp, unity, zero);
          end
          if ($urandom_range(0, 9) != 0) begin
            queue_req(MODE_COMMIT, raw_t, scaled_t, interp, unity, zero);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0] r;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] pd;
    int unsigned       last_period;
    logic [THRESH_W-1:0] last_thresh;

    // Hold reset low, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset register values.
    pd = TIME_W'(PERIOD_RST);
    // Begin and commit before any timing has started: no initialisation.
    queue_req(MODE_COMMIT, '0, '0, 1'b0, 1'b1, 1'b0);
    queue_req(MODE_BEGIN, '0, '0, 1'b0, 1'b1, 1'b0);
    // First advance loads the samples and sees no mode change.
    r = 64'd1000;
    s = 64'd5000;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b1, 1'b0);
    r = r + pd;
    s = s + pd;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b1, 1'b0);
    // Switch interpolation on: new epoch, presentation becomes separate.
    r = r + pd / 2;
    s = s + pd / 2;
    queue_req(MODE_ADVANCE, r, s, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_BEGIN, r, s, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_COMMIT, r, s, 1'b1, 1'b1, 1'b0);
    // Raw gap exactly at the threshold, then one above it.
    r = r + TIME_W'(THRESH_RST);
    s = s + 3 * pd;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b0);
    r = r + TIME_W'(THRESH_RST) + 1;
    s = s + pd;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b0);
    // Both clocks step backwards.
    r = r - 500;
    s = s - 500;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b0);
    // Scaled gap beyond 32 bits: the gap saturates and the tick count caps.
    r = r + 1000;
    s = s + 64'h2_0000_0000;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b0);
    // Time stopped, then unity and zero flagged together.
    r = r + 1000;
    s = s + 1000;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b1);
    r = r + 1000;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b1, 1'b1);
    // Timer reset at the top of the range, then an advance that wraps to zero.
    queue_req(MODE_RESET, '1, '1, 1'b0, 1'b1, 1'b0);
    queue_req(MODE_ADVANCE, '0, '0, 1'b0, 1'b0, 1'b0);
    // Commit with no tick open, then a begin issued twice.
    queue_req(MODE_COMMIT, '0, '0, 1'b0, 1'b0, 1'b0);
    queue_req(MODE_BEGIN, '1, '0, 1'b1, 1'b1, 1'b1);
    queue_req(MODE_BEGIN, '0, '1, 1'b0, 1'b0, 1'b0);
    queue_req(MODE_COMMIT, '1, '1, 1'b1, 1'b0, 1'b1);
    // Exact multiples of the period, interpolated and not.
    r = 64'd1000;
    s = 3 * pd;
    queue_req(MODE_ADVANCE, r, s, 1'b1, 1'b1, 1'b0);
    r = r + 1000;
    s = s + 2 * pd;
    queue_req(MODE_ADVANCE, r, s, 1'b0, 1'b0, 1'b0);
    queue_req(MODE_RESET, '0, '0, 1'b1, 1'b0, 1'b1);
    settle();

    // Short period, zero threshold: every forward raw step is abnormal.
    write_reg(CFG_SIM_PERIOD, 32'd8333333);
    write_reg(CFG_GAP_THRESHOLD, '0);
    queue_random_traffic(250, rand64(), rand64(), 8333333, '0);
    settle();

    // Long period with junk in the upper write bits, widest threshold, clocks near wrap.
    write_reg(CFG_SIM_PERIOD, {2'b10, 30'd1000000000});
    write_reg(CFG_GAP_THRESHOLD, '1);
    queue_random_traffic(300, 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2000000000),
                         64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2000000000),
                         1000000000, '1);
    settle();

    // Zero period: the tick loop is bounded only by its cap.
    write_reg(CFG_SIM_PERIOD, '0);
    write_reg(CFG_GAP_THRESHOLD, THRESH_RST);
    queue_random_traffic(250, rand64(), rand64(), 0, THRESH_RST);
    settle();

    // Largest period the register holds; writes to unknown indexes are dropped.
    write_reg(CFG_SIM_PERIOD, '1);
    write_reg(CFG_GAP_THRESHOLD, 32'd16666666);
    write_reg(CFG_SPARE_LO, CFG_DAT_W'(rand64()));
    write_reg(CFG_SPARE_HI, CFG_DAT_W'(rand64()));
    queue_random_traffic(350, rand64(), rand64(), (1 << PERIOD_W) - 1, 32'd16666666);
    settle();

    // Random register values inside the usual range.
    last_period = $urandom_range(8333333, 1000000000);
    last_thresh = $urandom;
    write_reg(CFG_SIM_PERIOD, last_period);
    write_reg(CFG_GAP_THRESHOLD, last_thresh);
    queue_random_traffic(700, rand64(), rand64(), last_period, last_thresh);
    settle();

    $display("Summary: %0d requests over six register settings, %0d results checked",
             reqs_accepted, results_seen);
    $display("Summary: %0d frames hit the tick cap, %0d frame gaps saturated, %0d mismatches",
             capped_frames, saturated_gaps, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
